>>> src/shp_pkg.sv
// Package for the slice header parser: phase codes, element codes, error codes
// and register indexes. No dependencies.
package shp_pkg;

  typedef enum logic [4:0] {
    PH_FIRST_MB  = 5'd0,  PH_SLICE_TYPE = 5'd1,  PH_PPS_ID   = 5'd2,
    PH_FRAME_NUM = 5'd3,  PH_IDR_ID     = 5'd4,  PH_POC_LSB  = 5'd5,
    PH_POC_BOT   = 5'd6,  PH_POC_D0     = 5'd7,  PH_POC_D1   = 5'd8,
    PH_REDUNDANT = 5'd9,  PH_DIRECT     = 5'd10, PH_OVERRIDE = 5'd11,
    PH_REF_L0    = 5'd12, PH_REF_L1     = 5'd13, PH_MODF_L0  = 5'd14,
    PH_MODF_L1   = 5'd15, PH_NO_OUTPUT  = 5'd16, PH_LONG_TERM = 5'd17,
    PH_ADAPTIVE  = 5'd18, PH_QP_DELTA   = 5'd19, PH_QP       = 5'd20,
    PH_DEBLOCK   = 5'd21, PH_ALPHA      = 5'd22, PH_BETA     = 5'd23,
    PH_MOD_OP0   = 5'd24, PH_MOD_ARG0   = 5'd25, PH_MOD_OP1  = 5'd26,
    PH_MOD_ARG1  = 5'd27, PH_MMCO_OP    = 5'd28, PH_MMCO_ARG = 5'd29,
    PH_SPARE     = 5'd30, PH_IDLE       = 5'd31
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_PPS = 2'd1, ERR_LONG = 2'd2, ERR_RSVD = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    REG_PPS = 3'd0, REG_FNUM = 3'd1, REG_POCT = 3'd2, REG_POCW = 3'd3,
    REG_FLAGS = 3'd4, REG_L0 = 3'd5, REG_L1 = 3'd6, REG_QP = 3'd7
  } reg_e;

  localparam int unsigned QpBase    = 26;
  localparam int unsigned KindCount = 5;
  localparam int unsigned ModEndOp  = 3;
  localparam int unsigned MaxZeros  = 30;

  typedef struct packed {
    logic [7:0] pps_id;
    logic [4:0] fnum_w;
    logic [1:0] poc_type;
    logic [4:0] poc_w;
    logic [3:0] flags;
    logic [4:0] l0_def;
    logic [4:0] l1_def;
    logic [5:0] qp_off;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  id;
    logic [31:0] value;
    logic        last;
    logic [1:0]  err;
  } result_t;

endpackage

>>> src/shp_cfg_regs.sv
// APB register file for the slice header parser configuration.
// Depends on shp_pkg.
module shp_cfg_regs import shp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pps_id: 8'd0, fnum_w: 5'd4, poc_type: 2'd0, poc_w: 5'd4,
                 flags: 4'd0, l0_def: 5'd0, l1_def: 5'd0, qp_off: 6'd0};
    end else if (psel && penable && pwrite) begin
      case (reg_e'(idx))
        REG_PPS:   cfg_q.pps_id   <= pwdata[7:0];
        REG_FNUM:  cfg_q.fnum_w   <= pwdata[4:0];
        REG_POCT:  cfg_q.poc_type <= pwdata[1:0];
        REG_POCW:  cfg_q.poc_w    <= pwdata[4:0];
        REG_FLAGS: cfg_q.flags    <= pwdata[3:0];
        REG_L0:    cfg_q.l0_def   <= pwdata[4:0];
        REG_L1:    cfg_q.l1_def   <= pwdata[4:0];
        REG_QP:    cfg_q.qp_off   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_e'(idx))
      REG_PPS:   prdata = {24'd0, cfg_q.pps_id};
      REG_FNUM:  prdata = {27'd0, cfg_q.fnum_w};
      REG_POCT:  prdata = {30'd0, cfg_q.poc_type};
      REG_POCW:  prdata = {27'd0, cfg_q.poc_w};
      REG_FLAGS: prdata = {28'd0, cfg_q.flags};
      REG_L0:    prdata = {27'd0, cfg_q.l0_def};
      REG_L1:    prdata = {27'd0, cfg_q.l1_def};
      REG_QP:    prdata = {26'd0, cfg_q.qp_off};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

>>> src/shp_core.sv
// Per-bit parse step: phase register, Exp-Golomb decoding and result forming.
// Up to three results per bit leave on a combinational bundle. Depends on shp_pkg.
module shp_core import shp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       step_i,
  input  logic       bit_i,
  input  logic       start_i,
  input  logic       idr_i,
  output logic [1:0] res_n_o,
  output result_t    res0_o,
  output result_t    res1_o,
  output result_t    res2_o
);

  phase_e      phase_q, phase_d;
  logic [4:0]  zeros_q, zeros_d;
  logic [31:0] acc_q, acc_d;
  logic [4:0]  left_q, left_d;
  logic        idr_q, idr_d;
  logic [2:0]  kind_q, kind_d;
  logic [2:0]  mop_q, mop_d;
  logic [1:0]  extra_q, extra_d;

  // working copies after a start bit
  phase_e      ph;
  logic [4:0]  zc;
  logic [31:0] ac;
  logic [4:0]  bl;
  logic        idr;
  logic [2:0]  kind;
  logic [2:0]  mop;
  logic [1:0]  extra;

  logic [1:0]  n;
  result_t     r [3];
  logic        done;
  logic [31:0] v, sv, val, acc_sh;
  logic [4:0]  ep;

  function automatic logic is_fixed(input logic [4:0] p);
    return p == 5'd3 || p == 5'd5 || p == 5'd10 || p == 5'd11 || p == 5'd14 ||
           p == 5'd15 || p == 5'd16 || p == 5'd17 || p == 5'd18;
  endfunction

  function automatic logic is_sgn(input logic [4:0] p);
    return p == 5'd6 || p == 5'd7 || p == 5'd8 || p == 5'd19 || p == 5'd22 ||
           p == 5'd23;
  endfunction

  function automatic logic [4:0] clampw(input logic [4:0] w);
    return (w < 5'd4) ? 5'd4 : ((w > 5'd16) ? 5'd16 : w);
  endfunction

  // slice kind: value modulo five, folding hex digits since 16 is 1 modulo 5
  function automatic logic [2:0] mod5(input logic [31:0] x);
    logic [6:0] s1;
    logic [4:0] s2;
    s1 = 7'(x[3:0]) + 7'(x[7:4]) + 7'(x[11:8]) + 7'(x[15:12]) +
         7'(x[19:16]) + 7'(x[23:20]) + 7'(x[27:24]) + 7'(x[31:28]);
    s2 = 5'(s1[3:0]) + 5'(s1[6:4]);
    if (s2 >= 5'd20) s2 = s2 - 5'd20;
    else if (s2 >= 5'd15) s2 = s2 - 5'd15;
    else if (s2 >= 5'd10) s2 = s2 - 5'd10;
    else if (s2 >= 5'd5) s2 = s2 - 5'd5;
    return s2[2:0];
  endfunction

  function automatic logic applies(input logic [4:0] p, input cfg_t c,
                                   input logic id, input logic [2:0] k);
    logic t0, t1;
    t0 = c.poc_type == 2'd0;
    t1 = c.poc_type == 2'd1;
    case (p)
      5'd3, 5'd19:        return 1'b1;
      5'd4, 5'd16, 5'd17: return id;
      5'd5:               return t0;
      5'd6:               return t0 && c.flags[0];
      5'd7:               return t1 && !c.flags[3];
      5'd8:               return t1 && !c.flags[3] && c.flags[0];
      5'd9:               return c.flags[1];
      5'd10, 5'd15:       return k == 3'd1;
      5'd11, 5'd14:       return k == 3'd0 || k == 3'd1 || k == 3'd3;
      5'd18:              return !id;
      default:            return 1'b0;
    endcase
  endfunction

  // next applicable element after p; at most 17 independent tests
  function automatic logic [4:0] after(input logic [4:0] p, input cfg_t c,
                                       input logic id, input logic [2:0] k);
    logic [4:0] res;
    res = 5'd31;
    for (int i = 19; i >= 3; i--) begin
      if (5'(i) > p && applies(5'(i), c, id, k)) res = 5'(i);
    end
    return res;
  endfunction

  always_comb begin
    logic [31:0] off;
    ph = phase_q; zc = zeros_q; ac = acc_q; bl = left_q; idr = idr_q;
    kind = kind_q; mop = mop_q; extra = extra_q;
    if (start_i) begin
      idr = idr_i; kind = 3'd0; mop = 3'd0; extra = 2'd0;
      ph = PH_FIRST_MB; zc = 5'd0; ac = 32'd0; bl = 5'd0;
    end
    phase_d = ph; zeros_d = zc; acc_d = ac; left_d = bl; idr_d = idr;
    kind_d = kind; mop_d = mop; extra_d = extra;
    n = 2'd0;
    for (int i = 0; i < 3; i++) r[i] = '0;
    done = 1'b0; v = 32'd0; ep = 5'd31;
    acc_sh = {ac[30:0], bit_i};
    off = {{26{cfg_i.qp_off[5]}}, cfg_i.qp_off};

    if (ph == PH_IDLE || ph == PH_SPARE || ph == PH_QP) begin
      phase_d = PH_IDLE;
    end else if (is_fixed(ph)) begin
      acc_d = acc_sh;
      left_d = (bl != 5'd0) ? bl - 5'd1 : 5'd0;
      if (left_d == 5'd0) begin
        done = 1'b1; v = acc_sh;
      end
    end else if (bl == 5'd0) begin
      if (!bit_i) begin
        zeros_d = zc + 5'd1;
        if (zeros_d > 5'(MaxZeros)) begin
          n = 2'd1;
          r[0].id = (ph == PH_MOD_OP0 || ph == PH_MOD_ARG0) ? 5'd14 :
                    (ph == PH_MOD_OP1 || ph == PH_MOD_ARG1) ? 5'd15 :
                    (ph == PH_MMCO_OP || ph == PH_MMCO_ARG) ? 5'd18 : ph;
          r[0].last = 1'b1; r[0].err = ERR_LONG;
          zeros_d = 5'd0; phase_d = PH_IDLE;
        end
      end else if (zc == 5'd0) begin
        done = 1'b1; v = 32'd0;
      end else begin
        left_d = zc; acc_d = 32'd0;
      end
    end else begin
      acc_d = acc_sh;
      left_d = bl - 5'd1;
      if (left_d == 5'd0) begin
        done = 1'b1;
        v = ((32'd1 << zc) - 32'd1) + acc_sh;
      end
    end

    sv = v[0] ? ({1'b0, v[31:1]} + 32'd1) : (32'd0 - {1'b0, v[31:1]});
    val = is_sgn(ph) ? sv : v;
    r[0].value = val;
    r[0].id = done ? ph : r[0].id;

    if (done) begin
      n = 2'd1; ep = 5'd31;
      case (ph)
        PH_SLICE_TYPE: begin
          kind_d = mod5(v); ep = 5'd2;
        end
        PH_PPS_ID: begin
          if (v != {24'd0, cfg_i.pps_id}) begin
            r[0].last = 1'b1; r[0].err = ERR_PPS;
          end else ep = after(5'd2, cfg_i, idr, kind);
        end
        PH_OVERRIDE: begin
          if (v != 32'd0) ep = 5'd12;
          else begin
            n = 2'd3;
            r[1].id = 5'd12; r[1].value = {27'd0, cfg_i.l0_def};
            r[2].id = 5'd13; r[2].value = {27'd0, cfg_i.l1_def};
            ep = after(5'd13, cfg_i, idr, kind);
          end
        end
        PH_REF_L0: ep = (kind == 3'd1) ? 5'd13 : after(5'd13, cfg_i, idr, kind);
        PH_MODF_L0: ep = (v != 32'd0) ? PH_MOD_OP0 : after(5'd14, cfg_i, idr, kind);
        PH_MODF_L1: ep = (v != 32'd0) ? PH_MOD_OP1 : after(5'd15, cfg_i, idr, kind);
        PH_ADAPTIVE: ep = (v != 32'd0) ? PH_MMCO_OP : after(5'd18, cfg_i, idr, kind);
        PH_MOD_OP0, PH_MOD_OP1: begin
          n = 2'd0;
          if (v != 32'(ModEndOp)) begin
            extra_d = 2'd1; ep = ph + 5'd1;
          end else ep = after((ph == PH_MOD_OP0) ? 5'd14 : 5'd15, cfg_i, idr, kind);
        end
        PH_MOD_ARG0, PH_MOD_ARG1: begin
          n = 2'd0; extra_d = 2'd0; ep = ph - 5'd1;
        end
        PH_MMCO_OP: begin
          n = 2'd0;
          if (v == 32'd0) ep = after(5'd18, cfg_i, idr, kind);
          else begin
            mop_d = (v > 32'd7) ? 3'd7 : v[2:0];
            extra_d = (v == 32'd3) ? 2'd2 :
                      ((v == 32'd5 || v > 32'd6) ? 2'd0 : 2'd1);
            ep = (extra_d != 2'd0) ? PH_MMCO_ARG : PH_MMCO_OP;
          end
        end
        PH_MMCO_ARG: begin
          n = 2'd0; extra_d = extra - 2'd1;
          ep = (extra_d != 2'd0) ? PH_MMCO_ARG : PH_MMCO_OP;
        end
        PH_QP_DELTA: begin
          n = 2'd2;
          r[1].id = 5'd20;
          r[1].value = 32'(QpBase) + off + val;
          r[1].last = !cfg_i.flags[2];
          ep = cfg_i.flags[2] ? 5'd21 : 5'd31;
        end
        PH_DEBLOCK: begin
          r[0].last = (v == 32'd1); ep = (v == 32'd1) ? 5'd31 : 5'd22;
        end
        PH_ALPHA: ep = 5'd23;
        PH_BETA: r[0].last = 1'b1;
        PH_FIRST_MB: ep = 5'd1;
        default: ep = after(ph, cfg_i, idr, kind);
      endcase
      // enter the next phase
      phase_d = phase_e'(ep);
      zeros_d = 5'd0; acc_d = 32'd0;
      if (ep == 5'd3) left_d = clampw(cfg_i.fnum_w);
      else if (ep == 5'd5) left_d = clampw(cfg_i.poc_w);
      else left_d = is_fixed(ep) ? 5'd1 : 5'd0;
    end
    res_n_o = n;
    res0_o = r[0]; res1_o = r[1]; res2_o = r[2];
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; zeros_q <= '0; acc_q <= '0; left_q <= '0;
      idr_q <= 1'b0; kind_q <= '0; mop_q <= '0; extra_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d; zeros_q <= zeros_d; acc_q <= acc_d; left_q <= left_d;
      idr_q <= idr_d; kind_q <= kind_d; mop_q <= mop_d; extra_q <= extra_d;
    end
  end

endmodule

>>> src/shp_out_queue.sv
// Result queue: takes up to three results a cycle, hands one out per transaction.
// Depends on shp_pkg.
module shp_out_queue import shp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [1:0] push_n_i,
  input  result_t    push0_i,
  input  result_t    push1_i,
  input  result_t    push2_i,
  output logic       room_o,
  output logic       valid_o,
  input  logic       ready_i,
  output result_t    head_o
);

  localparam int Depth = 8;
  result_t    mem_q [Depth];
  logic [2:0] wp_q, rp_q;
  logic [3:0] cnt_q;
  logic       pop;
  logic [1:0] nin;

  assign valid_o = cnt_q != 4'd0;
  assign head_o  = mem_q[rp_q];
  assign pop     = valid_o && ready_i;
  assign nin     = push_i ? push_n_i : 2'd0;
  // three free slots keep one bit per cycle flowing
  assign room_o  = cnt_q <= 4'(Depth - 3);

  // store results
  always_ff @(posedge clk_i) begin
    if (nin > 2'd0) mem_q[wp_q] <= push0_i;
    if (nin > 2'd1) mem_q[3'(wp_q + 3'd1)] <= push1_i;
    if (nin > 2'd2) mem_q[3'(wp_q + 3'd2)] <= push2_i;
  end

  // advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + 3'(nin);
      rp_q  <= rp_q + 3'(pop);
      cnt_q <= cnt_q + 4'(nin) - 4'(pop);
    end
  end

endmodule

>>> src/slice_header_parser_unit.sv
// Slice header parser: one header bit per input transaction, MSB first.
// Input channel: bit_in_i, header_start_i, idr_slice_i with in_valid_i/in_ready_o.
// Output channel: element_id_o, element_value_o, last_element_o, error_code_o
// with out_valid_o/out_ready_i, one syntax element per transaction.
// Configuration over APB, register i at byte address 4*i, to be written when idle
// by the user (the block does not enforce it). Throughput: one bit per cycle while
// the queue has room; the parse step is combinational logic from the state registers
// into an eight-entry result queue, which a result enters with the bit completing it.
// A bit can give up to three results; they leave one per cycle.
// When the receiver stalls, results collect in the queue and in_ready_o
// drops once fewer than three slots are free.
// Reset leaves the parser idle; bits before a header start are dropped.
// Depends on shp_pkg, shp_cfg_regs, shp_core, shp_out_queue.
module slice_header_parser_unit import shp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        bit_in_i,
  input  logic        header_start_i,
  input  logic        idr_slice_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  element_id_o,
  output logic signed [31:0] element_value_o,
  output logic        last_element_o,
  output logic [1:0]  error_code_o
);

  cfg_t       cfg;
  logic       step;
  logic [1:0] res_n;
  result_t    r0, r1, r2, head;

  assign step = in_valid_i && in_ready_o;

  shp_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .pready, .cfg_o(cfg)
  );

  shp_core u_core (
    .clk_i, .rst_ni, .cfg_i(cfg), .step_i(step), .bit_i(bit_in_i),
    .start_i(header_start_i), .idr_i(idr_slice_i), .res_n_o(res_n),
    .res0_o(r0), .res1_o(r1), .res2_o(r2)
  );

  shp_out_queue u_q (
    .clk_i, .rst_ni, .push_i(step), .push_n_i(res_n), .push0_i(r0),
    .push1_i(r1), .push2_i(r2), .room_o(in_ready_o), .valid_o(out_valid_o),
    .ready_i(out_ready_i), .head_o(head)
  );

  assign element_id_o    = head.id;
  assign element_value_o = head.value;
  assign last_element_o  = head.last;
  assign error_code_o    = head.err;

`ifndef SYNTH
  // an error result always closes the header
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ERR_NONE |-> last_element_o)
    else $error("error result without last flag");
  // no bit is taken while the queue lacks room
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> !step)
    else $error("bit accepted without queue room");
  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(element_id_o))
    else $error("stalled result changed");
`endif

endmodule
